[sv/bda_pkg.sv]
// shared types, constants and helpers for the banker's algorithm admission checker
package bda_pkg;

  localparam int NUM_PROCESSES = 4;
  localparam int NUM_RESOURCES = 4;

  localparam int PROC_W  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int COUNT_W = 8;
  localparam int WORK_W  = 12;
  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  // input beat layout
  localparam int IN_ACT_LSB  = 0;
  localparam int IN_ACT_W    = 3;
  localparam int IN_PROC_LSB = 3;
  localparam int IN_PROC_W   = 4;
  localparam int IN_AMT_LSB  = 7;
  localparam int IN_AMT_SLOTS = 4;
  localparam int IN_DATA_W   = 40;

  // output beat layout
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int OUT_DATA_W = 8;

  // action codes
  localparam logic [IN_ACT_W-1:0] ACT_LOAD_MAX   = 3'd0;
  localparam logic [IN_ACT_W-1:0] ACT_LOAD_ALLOC = 3'd1;
  localparam logic [IN_ACT_W-1:0] ACT_SET_AVAIL  = 3'd2;
  localparam logic [IN_ACT_W-1:0] ACT_CHECK      = 3'd3;
  localparam logic [IN_ACT_W-1:0] ACT_REQUEST    = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ORDER   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SAFE      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_UNSAFE    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ABOVE_MAX = 3'd4;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WORK_W-1:0]  work_t;
  typedef count_t [NUM_RESOURCES-1:0] row_t;
  typedef work_t  [NUM_RESOURCES-1:0] work_vec_t;
  typedef logic [PROC_W-1:0] proc_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VERDICT
  } state_t;

  // what one lane reports for its process
  typedef struct packed {
    logic      fits;
    work_vec_t sum;
  } lane_res_t;

  typedef lane_res_t [NUM_PROCESSES-1:0] lane_res_vec_t;

  // merged outcome of one scan step
  typedef struct packed {
    logic      found;
    proc_idx_t idx;
    work_vec_t work;
  } pick_t;

  function automatic count_t need_of(input count_t m, input count_t a);
    return (m >= a) ? count_t'(m - a) : '0;
  endfunction

  function automatic work_t sat_add(input work_t w, input count_t a);
    logic [WORK_W:0] s;
    s = {1'b0, w} + (WORK_W + 1)'(a);
    return (s > {1'b0, WORK_MAX}) ? WORK_MAX : s[WORK_W-1:0];
  endfunction

endpackage

[sv/bankers_deadlock_avoidance_core.sv]
// top level of the banker's algorithm admission checker
//
//  channel   | dir | beat contents
//  s_*       | in  | s_tdata: action[2:0] process[6:3] amount_0..amount_3[38:7], pad
//  m_*       | out | m_tdata: order_process[3:0] status[6:4], pad; m_tuser: kind;
//            |     | m_tlast: last
//
// row loads, set available, unused codes and refused requests: one beat
// safety check and granted request: a start step, then one order beat per finished
// process in the scan (one lane per process, all rows tested at once), a step in which no
// lane fits, then the verdict beat
// one item at a time; the scan holds while the output register is not taken
// rst clears the tables, available vector, scan state and output valid
module bankers_deadlock_avoidance_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // action, process, amount_0, amount_1, amount_2, amount_3
  input  logic [bda_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // order_process, status
  output logic [bda_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind
  output logic [bda_pkg::KIND_W-1:0]     m_tuser,
  output logic                           m_tlast
);

  bda_pkg::state_t state, state_next;

  bda_pkg::row_t max_tab   [bda_pkg::NUM_PROCESSES];
  bda_pkg::row_t alloc_tab [bda_pkg::NUM_PROCESSES];
  bda_pkg::row_t avail;
  bda_pkg::work_vec_t work;
  logic [bda_pkg::NUM_PROCESSES-1:0] finished;
  logic is_req;
  bda_pkg::proc_idx_t req_proc;
  bda_pkg::row_t req_amt;

  logic [bda_pkg::KIND_W-1:0]   out_kind;
  logic [bda_pkg::IN_PROC_W-1:0] out_proc;
  logic [bda_pkg::STATUS_W-1:0] out_status;

  logic [bda_pkg::IN_ACT_W-1:0]  act;
  logic [bda_pkg::IN_PROC_W-1:0] proc_in;
  bda_pkg::row_t amt_in;
  bda_pkg::proc_idx_t rd_idx;
  bda_pkg::row_t max_rd, alloc_rd;
  logic proc_ok, max_bad, alloc_bad, req_bad, safe;

  logic out_free, accept, emit, emit_last;
  logic [bda_pkg::KIND_W-1:0]   emit_kind;
  logic [bda_pkg::IN_PROC_W-1:0] emit_proc;
  logic [bda_pkg::STATUS_W-1:0] emit_status;
  logic wr_max, wr_alloc, wr_avail, grant, start_scan, step, rollback, is_req_next;

  bda_pkg::lane_res_vec_t lanes;
  bda_pkg::pick_t pick;

  // input unpack
  always_comb begin
    act     = s_tdata[bda_pkg::IN_ACT_LSB +: bda_pkg::IN_ACT_W];
    proc_in = s_tdata[bda_pkg::IN_PROC_LSB +: bda_pkg::IN_PROC_W];
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++)
      amt_in[j] = s_tdata[bda_pkg::IN_AMT_LSB + bda_pkg::COUNT_W*j +: bda_pkg::COUNT_W];
  end

  assign proc_ok = (int'(proc_in) < bda_pkg::NUM_PROCESSES);

  // single row read port: input row while idle, granted row for rollback
  assign rd_idx   = (state == bda_pkg::ST_IDLE) ? proc_in[bda_pkg::PROC_W-1:0] : req_proc;
  assign max_rd   = max_tab[rd_idx];
  assign alloc_rd = alloc_tab[rd_idx];

  always_comb begin
    max_bad   = 1'b0;
    alloc_bad = 1'b0;
    req_bad   = 1'b0;
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
      if (amt_in[j] < alloc_rd[j]) max_bad = 1'b1;
      if (amt_in[j] > max_rd[j]) alloc_bad = 1'b1;
      if (amt_in[j] > bda_pkg::need_of(max_rd[j], alloc_rd[j]) || amt_in[j] > avail[j])
        req_bad = 1'b1;
    end
  end

  assign safe = &finished;

  for (genvar p = 0; p < bda_pkg::NUM_PROCESSES; p++) begin : g_lane
    bda_lane u_lane (
      .work      (work),
      .max_row   (max_tab[p]),
      .alloc_row (alloc_tab[p]),
      .done      (finished[p]),
      .res       (lanes[p])
    );
  end

  bda_merge u_merge (
    .lanes (lanes),
    .pick  (pick)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == bda_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= bda_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_kind   = bda_pkg::KIND_ACK;
    emit_proc   = '0;
    emit_status = bda_pkg::STAT_ACCEPTED;
    emit_last   = 1'b1;
    wr_max      = 1'b0;
    wr_alloc    = 1'b0;
    wr_avail    = 1'b0;
    grant       = 1'b0;
    start_scan  = 1'b0;
    step        = 1'b0;
    rollback    = 1'b0;
    is_req_next = is_req;
    unique case (state)
      bda_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (act)
            bda_pkg::ACT_LOAD_MAX: begin
              emit = 1'b1;
              if (proc_ok && max_bad) emit_status = bda_pkg::STAT_ABOVE_MAX;
              wr_max = proc_ok && !max_bad;
            end
            bda_pkg::ACT_LOAD_ALLOC: begin
              emit = 1'b1;
              if (proc_ok && alloc_bad) emit_status = bda_pkg::STAT_ABOVE_MAX;
              wr_alloc = proc_ok && !alloc_bad;
            end
            bda_pkg::ACT_SET_AVAIL: begin
              emit     = 1'b1;
              wr_avail = 1'b1;
            end
            bda_pkg::ACT_CHECK: begin
              start_scan  = 1'b1;
              is_req_next = 1'b0;
              state_next  = bda_pkg::ST_SCAN;
            end
            bda_pkg::ACT_REQUEST: begin
              if (!proc_ok || req_bad) begin
                emit        = 1'b1;
                emit_kind   = bda_pkg::KIND_VERDICT;
                emit_status = bda_pkg::STAT_REFUSED;
              end else begin
                grant       = 1'b1;
                start_scan  = 1'b1;
                is_req_next = 1'b1;
                state_next  = bda_pkg::ST_SCAN;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      bda_pkg::ST_SCAN: begin
        if (out_free) begin
          if (pick.found) begin
            emit      = 1'b1;
            emit_kind = bda_pkg::KIND_ORDER;
            emit_proc = bda_pkg::IN_PROC_W'(pick.idx);
            emit_last = 1'b0;
            step      = 1'b1;
          end else begin
            state_next = bda_pkg::ST_VERDICT;
          end
        end
      end
      bda_pkg::ST_VERDICT: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_kind   = bda_pkg::KIND_VERDICT;
          emit_status = safe ? bda_pkg::STAT_SAFE : bda_pkg::STAT_UNSAFE;
          rollback    = is_req && !safe;
          state_next  = bda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bda_pkg::ST_IDLE;
      end
    endcase
  end

  // tables and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < bda_pkg::NUM_PROCESSES; p++) begin
        max_tab[p]   <= '0;
        alloc_tab[p] <= '0;
      end
      avail    <= '0;
      work     <= '0;
      finished <= '0;
      is_req   <= 1'b0;
    end else begin
      is_req <= is_req_next;
      if (wr_max)   max_tab[rd_idx]   <= amt_in;
      if (wr_alloc) alloc_tab[rd_idx] <= amt_in;
      if (wr_avail) avail <= amt_in;
      if (grant) begin
        for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
          alloc_tab[rd_idx][j] <= alloc_rd[j] + amt_in[j];
          avail[j]             <= avail[j] - amt_in[j];
        end
      end
      if (rollback) begin
        for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
          alloc_tab[rd_idx][j] <= alloc_rd[j] - req_amt[j];
          avail[j]             <= avail[j] + req_amt[j];
        end
      end
      if (start_scan) begin
        finished <= '0;
        for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++)
          work[j] <= grant ? bda_pkg::work_t'(avail[j] - amt_in[j])
                           : bda_pkg::work_t'(avail[j]);
      end
      if (step) begin
        finished[pick.idx] <= 1'b1;
        work               <= pick.work;
      end
    end
  end

  // granted request kept for a possible rollback
  always_ff @(posedge clk) begin
    if (grant) begin
      req_proc <= rd_idx;
      req_amt  <= amt_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_proc   <= emit_proc;
      out_status <= emit_status;
      m_tlast    <= emit_last;
    end
  end

  assign m_tdata = {{(bda_pkg::OUT_DATA_W - bda_pkg::IN_PROC_W - bda_pkg::STATUS_W){1'b0}},
                    out_status, out_proc};
  assign m_tuser = out_kind;

  // single-beat actions answer in the next cycle with a closing beat
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    accept && act != bda_pkg::ACT_CHECK && act != bda_pkg::ACT_REQUEST
    |=> m_tvalid && m_tlast)
    else $error("single-beat action did not answer with a closing beat");

  // order entries never close a run
  a_order_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bda_pkg::KIND_ORDER |-> !m_tlast)
    else $error("order entry marked last");

  // finished set only grows while scanning
  a_finished_grows: assert property (@(posedge clk) disable iff (rst)
    state == bda_pkg::ST_SCAN |=> (finished & $past(finished)) == $past(finished))
    else $error("finished process dropped during scan");

  // no new item while a check is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == bda_pkg::ST_SCAN || state == bda_pkg::ST_VERDICT |-> !accept)
    else $error("item accepted during scan");

endmodule

[sv/bda_lane.sv]
// one scan lane: fit test and released work vector for a single process
module bda_lane (
  input  bda_pkg::work_vec_t work,
  input  bda_pkg::row_t      max_row,
  input  bda_pkg::row_t      alloc_row,
  input  logic               done,
  output bda_pkg::lane_res_t res
);

  logic fit_all;

  always_comb begin
    fit_all = 1'b1;
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
      if (work[j] < bda_pkg::work_t'(bda_pkg::need_of(max_row[j], alloc_row[j])))
        fit_all = 1'b0;
      res.sum[j] = bda_pkg::sat_add(work[j], alloc_row[j]);
    end
    res.fits = fit_all && !done;
  end

endmodule

[sv/bda_merge.sv]
// merges lane results: lowest fitting process wins, its work vector goes forward
module bda_merge (
  input  bda_pkg::lane_res_vec_t lanes,
  output bda_pkg::pick_t         pick
);

  always_comb begin
    pick = '0;
    // walk down so the lowest index is left standing
    for (int i = bda_pkg::NUM_PROCESSES - 1; i >= 0; i--) begin
      if (lanes[i].fits) begin
        pick.found = 1'b1;
        pick.idx   = bda_pkg::proc_idx_t'(i);
        pick.work  = lanes[i].sum;
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the banker's algorithm admission checker
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PROC_SLOTS = 16;
  localparam int WORK_CEIL = 4095;
  localparam int RANDOM_ITEMS = 125;

  // action codes that the block acknowledges and otherwise ignores
  localparam logic [bda_pkg::IN_ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [bda_pkg::IN_ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [bda_pkg::IN_ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct packed {
    logic [bda_pkg::KIND_W-1:0]   kind;
    logic [3:0]                   proc;
    logic [bda_pkg::STATUS_W-1:0] status;
    logic                         last;
  } beat_t;

  typedef struct {
    logic [bda_pkg::IN_ACT_W-1:0] act;
    logic [3:0]                   proc;
    logic [31:0]                  amts;
    bit                           typed;
    logic [bda_pkg::KIND_W-1:0]   kind;
    logic [bda_pkg::STATUS_W-1:0] status;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bda_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bda_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [bda_pkg::KIND_W-1:0]     m_tuser;
  logic                           m_tlast;

  bankers_deadlock_avoidance_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  bda_pkg::count_t max_rows   [PROC_SLOTS][bda_pkg::NUM_RESOURCES];
  bda_pkg::count_t alloc_rows [PROC_SLOTS][bda_pkg::NUM_RESOURCES];
  bda_pkg::count_t avail_vec  [bda_pkg::NUM_RESOURCES];
  int              scan_work  [bda_pkg::NUM_RESOURCES];

  beat_t     pending_beats[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int need_cnt(int p, int j);
    return (max_rows[p][j] >= alloc_rows[p][j]) ? max_rows[p][j] - alloc_rows[p][j] : 0;
  endfunction

  function automatic void add_beat(logic [bda_pkg::KIND_W-1:0] kind, int p,
                                   logic [bda_pkg::STATUS_W-1:0] status, bit last,
                                   bit record);
    beat_t b;
    b.kind = kind;
    b.proc = 4'(p);
    b.status = status;
    b.last = last;
    if (record) pending_beats.push_back(b);
  endfunction

  // restarts from process 0 after every finished process
  function automatic bit run_safety_scan(bit record);
    logic [PROC_SLOTS-1:0] done;
    bit hit, fits;
    int s;
    done = '0;
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) scan_work[j] = avail_vec[j];
    for (int pass = 0; pass < bda_pkg::NUM_PROCESSES; pass++) begin
      hit = 1'b0;
      for (int q = 0; q < bda_pkg::NUM_PROCESSES && !hit; q++) begin
        if (!done[q]) begin
          fits = 1'b1;
          for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++)
            if (scan_work[j] < need_cnt(q, j)) fits = 1'b0;
          if (fits) begin
            hit = 1'b1;
            done[q] = 1'b1;
            for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
              s = scan_work[j] + alloc_rows[q][j];
              scan_work[j] = (s > WORK_CEIL) ? WORK_CEIL : s;
            end
            add_beat(bda_pkg::KIND_ORDER, q, bda_pkg::STAT_ACCEPTED, 1'b0, record);
          end
        end
      end
    end
    return done[bda_pkg::NUM_PROCESSES-1:0] == {bda_pkg::NUM_PROCESSES{1'b1}};
  endfunction

  function automatic void predict_admission(logic [bda_pkg::IN_ACT_W-1:0] act,
                                            logic [3:0] p, logic [31:0] amts, bit record);
    bda_pkg::count_t a [bda_pkg::NUM_RESOURCES];
    bit ok, safe;
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) a[j] = amts[8*j +: 8];
    case (act)
      bda_pkg::ACT_LOAD_MAX, bda_pkg::ACT_LOAD_ALLOC: begin
        if (p >= bda_pkg::NUM_PROCESSES) begin
          add_beat(bda_pkg::KIND_ACK, 0, bda_pkg::STAT_ACCEPTED, 1'b1, record);
        end else begin
          ok = 1'b1;
          for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
            if (act == bda_pkg::ACT_LOAD_MAX && a[j] < alloc_rows[p][j]) ok = 1'b0;
            if (act == bda_pkg::ACT_LOAD_ALLOC && a[j] > max_rows[p][j]) ok = 1'b0;
          end
          if (ok) begin
            for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++)
              if (act == bda_pkg::ACT_LOAD_MAX) max_rows[p][j] = a[j];
              else alloc_rows[p][j] = a[j];
          end
          add_beat(bda_pkg::KIND_ACK, 0,
                   ok ? bda_pkg::STAT_ACCEPTED : bda_pkg::STAT_ABOVE_MAX, 1'b1, record);
        end
      end
      bda_pkg::ACT_SET_AVAIL: begin
        for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) avail_vec[j] = a[j];
        add_beat(bda_pkg::KIND_ACK, 0, bda_pkg::STAT_ACCEPTED, 1'b1, record);
      end
      bda_pkg::ACT_CHECK: begin
        safe = run_safety_scan(record);
        add_beat(bda_pkg::KIND_VERDICT, 0,
                 safe ? bda_pkg::STAT_SAFE : bda_pkg::STAT_UNSAFE, 1'b1, record);
      end
      bda_pkg::ACT_REQUEST: begin
        ok = (p < bda_pkg::NUM_PROCESSES);
        if (ok)
          for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++)
            if (a[j] > need_cnt(p, j) || a[j] > avail_vec[j]) ok = 1'b0;
        if (!ok) begin
          add_beat(bda_pkg::KIND_VERDICT, 0, bda_pkg::STAT_REFUSED, 1'b1, record);
        end else begin
          // tentative grant, undone when the scan finds the state unsafe
          for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
            alloc_rows[p][j] = alloc_rows[p][j] + a[j];
            avail_vec[j] = avail_vec[j] - a[j];
          end
          safe = run_safety_scan(record);
          if (!safe)
            for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
              alloc_rows[p][j] = alloc_rows[p][j] - a[j];
              avail_vec[j] = avail_vec[j] + a[j];
            end
          add_beat(bda_pkg::KIND_VERDICT, 0,
                   safe ? bda_pkg::STAT_SAFE : bda_pkg::STAT_UNSAFE, 1'b1, record);
        end
      end
      default: add_beat(bda_pkg::KIND_ACK, 0, bda_pkg::STAT_ACCEPTED, 1'b1, record);
    endcase
  endfunction

  // mostly well-formed actions on live rows, some noise
  task automatic pick_item(output logic [bda_pkg::IN_ACT_W-1:0] act, output logic [3:0] p,
                           output logic [31:0] amts);
    int r, v, lim;
    r = $urandom_range(0, 99);
    act = bda_pkg::ACT_CHECK;
    p = 4'($urandom_range(0, bda_pkg::NUM_PROCESSES - 1));
    amts = $urandom();
    if (r < 8) begin
      act = 3'($urandom_range(0, 7));
      p = 4'($urandom_range(0, 15));
    end else if (r < 55 && r >= 15) begin
      act = (r < 22) ? bda_pkg::ACT_LOAD_MAX :
            (r < 32) ? bda_pkg::ACT_LOAD_ALLOC : bda_pkg::ACT_SET_AVAIL;
      if (r >= 45) act = bda_pkg::ACT_REQUEST;
      for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
        case (act)
          bda_pkg::ACT_LOAD_MAX: v = alloc_rows[p][j] + $urandom_range(0, 6);
          bda_pkg::ACT_LOAD_ALLOC:
            v = $urandom_range(0, max_rows[p][j]) + ($urandom_range(0, 9) == 0);
          bda_pkg::ACT_SET_AVAIL: v = $urandom_range(0, 10);
          default: begin
            lim = (need_cnt(p, j) < avail_vec[j]) ? need_cnt(p, j) : avail_vec[j];
            v = $urandom_range(0, lim) + ($urandom_range(0, 7) == 0);
          end
        endcase
        if ($urandom_range(0, 11) == 0) v = $urandom_range(0, 255);
        amts[8*j +: 8] = (v > 255) ? 8'hff : 8'(v);
      end
    end else if (r >= 55) begin
      act = bda_pkg::ACT_REQUEST;
      for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
        lim = (need_cnt(p, j) < avail_vec[j]) ? need_cnt(p, j) : avail_vec[j];
        v = $urandom_range(0, lim);
        amts[8*j +: 8] = 8'(v);
      end
    end
  endtask

  // a valid that stays high for the next item is never lowered in between
  task automatic send_beat(logic [bda_pkg::IN_ACT_W-1:0] act, logic [3:0] p,
                           logic [31:0] amts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, amts, p, act};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic void add_row(logic [bda_pkg::IN_ACT_W-1:0] act, logic [3:0] p,
                                  logic [31:0] amts, bit typed,
                                  logic [bda_pkg::KIND_W-1:0] kind,
                                  logic [bda_pkg::STATUS_W-1:0] status);
    plan_row_t row;
    row.act = act;
    row.proc = p;
    row.amts = amts;
    row.typed = typed;
    row.kind = kind;
    row.status = status;
    plan.push_back(row);
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, checked against the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: beat expected none, actual kind %0d proc %0d status %0d last %0d",
                 $time, m_tuser, m_tdata[3:0], m_tdata[6:4], m_tlast);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, m_tuser);
        check_field("order_process", want.proc, m_tdata[3:0]);
        check_field("status", want.status, m_tdata[6:4]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bankers_deadlock_avoidance_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [bda_pkg::IN_ACT_W-1:0] act;
    logic [3:0]                   p;
    logic [31:0]                  amts;
    for (int i = 0; i < PROC_SLOTS; i++)
      for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) begin
        max_rows[i][j] = '0;
        alloc_rows[i][j] = '0;
      end
    for (int j = 0; j < bda_pkg::NUM_RESOURCES; j++) avail_vec[j] = '0;

    // all rows zero after reset: every process finishes in index order
    add_row(bda_pkg::ACT_CHECK, 4'd0, 32'h0, 0, bda_pkg::KIND_VERDICT, bda_pkg::STAT_SAFE);
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd0, 32'hffffffff, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_ALLOC, 4'd0, 32'hffffffff, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    // maximum below allocation, then allocation above maximum
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd0, 32'h00000000, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ABOVE_MAX);
    add_row(bda_pkg::ACT_LOAD_ALLOC, 4'd1, 32'h00000001, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ABOVE_MAX);
    // rows outside the process range and unused codes
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd15, 32'hffffffff, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_ALLOC, 4'd4, 32'hffffffff, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(ACT_SPARE_A, 4'd0, 32'hffffffff, 1, bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(ACT_SPARE_B, 4'd9, 32'h5a5a5a5a, 1, bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(ACT_SPARE_C, 4'd15, 32'h00000000, 1, bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_ALLOC, 4'd0, 32'h00000000, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd1, 32'h03030303, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd2, 32'h05050505, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd3, 32'h02020202, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_SET_AVAIL, 4'd0, 32'h01010101, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_CHECK, 4'd0, 32'h0, 0, bda_pkg::KIND_VERDICT, bda_pkg::STAT_UNSAFE);
    // refused requests: process out of range, above available, above need
    add_row(bda_pkg::ACT_REQUEST, 4'd4, 32'h00000000, 1,
            bda_pkg::KIND_VERDICT, bda_pkg::STAT_REFUSED);
    add_row(bda_pkg::ACT_REQUEST, 4'd1, 32'h00000002, 1,
            bda_pkg::KIND_VERDICT, bda_pkg::STAT_REFUSED);
    add_row(bda_pkg::ACT_SET_AVAIL, 4'd0, 32'hffffffff, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_REQUEST, 4'd1, 32'h02020202, 0,
            bda_pkg::KIND_VERDICT, bda_pkg::STAT_SAFE);
    add_row(bda_pkg::ACT_REQUEST, 4'd3, 32'h00000003, 1,
            bda_pkg::KIND_VERDICT, bda_pkg::STAT_REFUSED);
    // grant that leaves process 0 stuck, so it is rolled back
    add_row(bda_pkg::ACT_SET_AVAIL, 4'd0, 32'h05050505, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_REQUEST, 4'd2, 32'h04040404, 0,
            bda_pkg::KIND_VERDICT, bda_pkg::STAT_UNSAFE);
    add_row(bda_pkg::ACT_CHECK, 4'd0, 32'h0, 0, bda_pkg::KIND_VERDICT, bda_pkg::STAT_UNSAFE);
    add_row(bda_pkg::ACT_LOAD_MAX, 4'd0, 32'h01010101, 1,
            bda_pkg::KIND_ACK, bda_pkg::STAT_ACCEPTED);
    add_row(bda_pkg::ACT_CHECK, 4'd0, 32'h0, 0, bda_pkg::KIND_VERDICT, bda_pkg::STAT_SAFE);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_beat(plan[i].act, plan[i].proc, plan[i].amts);
      predict_admission(plan[i].act, plan[i].proc, plan[i].amts, !plan[i].typed);
      if (plan[i].typed) add_beat(plan[i].kind, 0, plan[i].status, 1'b1, 1'b1);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // some stretches run with no gaps on the input side
      if (i % 25 == 0) calm <= ($urandom_range(0, 3) == 0);
      pick_item(act, p, amts);
      send_beat(act, p, amts);
      predict_admission(act, p, amts, 1'b1);
    end
    s_tvalid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (3 * bda_pkg::NUM_PROCESSES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("bankers_deadlock_avoidance_core: match");
    end else begin
      $display("bankers_deadlock_avoidance_core: mismatch");
    end
    $finish;
  end

endmodule
